### sv/wga_pkg.sv
// Package for the waveset group averager: widths, status codes, controller states.
// Used by wga_divider and waveset_group_averager.
package wga_pkg;

  localparam int SampleDepth = 4096;
  localparam int MaxCycles   = 64;
  localparam int SampleBits  = 16;
  localparam int AddrW       = $clog2(SampleDepth);
  localparam int CidxW       = $clog2(MaxCycles);
  localparam int LenW        = AddrW + 1;
  localparam int NumW        = 26;
  localparam int DenW        = 14;
  localparam int AccW        = SampleBits + CidxW + 1;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_GIVEN    = 3'd2,
    ST_NONE     = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_GROUP_CYCLES = 2'd0,
    REG_USE_MEAN     = 2'd1,
    REG_NEG_FIRST    = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN_DIV,
    S_PRD,
    S_PMUL,
    S_PDIV0,
    S_PDIV,
    S_PSMP,
    S_PACC,
    S_AVG0,
    S_AVG
  } state_t;

endpackage

### sv/wga_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wga_pkg for operand widths.
module wga_divider import wga_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quot
);

  localparam int CntW = $clog2(NumW + 1);

  logic [DenW:0]     rem;
  logic [NumW-1:0]   shreg;
  logic [DenW-1:0]   den_q;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic [DenW:0]     trial;

  assign trial = {rem[DenW-1:0], shreg[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem   <= '0;
        shreg <= num;
        den_q <= den;
        cnt   <= CntW'(NumW);
      end else if (busy) begin
        if (trial >= {1'b0, den_q}) begin
          rem   <= trial - {1'b0, den_q};
          shreg <= {shreg[NumW-2:0], 1'b1};
        end else begin
          rem   <= trial;
          shreg <= {shreg[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = shreg;

endmodule

### sv/waveset_group_averager.sv
// Waveset group averager: a push that closes a group in mean-length mode also runs
// a length divide; a pull of a pending group runs one position divide per averaged
// wave cycle and then the final average divide, all on the shared bit-serial divider.
// Samples live in a 4096-entry store, cycle starts and lengths in 64-entry tables,
// all read through output registers. Depends on wga_pkg, wga_divider.
module waveset_group_averager import wga_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] sample_value
  input  logic [0:0]            s_axis_tuser,   // [0] action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [15:0] result_sample
  output logic                  m_axis_tlast,
  output logic [2:0]            m_axis_tuser,   // [2:0] status
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [6:0]            cfg_data
);

  logic signed [SampleBits-1:0] smem [SampleDepth];
  logic [LenW-1:0]  lmem [MaxCycles];
  logic [AddrW-1:0] tmem [MaxCycles];

  logic [6:0]       group_cycles;
  logic             use_mean, neg_first;
  logic [AddrW-1:0] wp;
  logic [LenW-1:0]  gcount, cur_len, pmax, psum, olen, opos;
  logic [6:0]       cidx, kcnt;
  logic             half, pending;
  state_t           state, state_next;

  logic [LenW-1:0]  rd_len;
  logic [AddrW-1:0] rd_start, start_hold, saddr;
  logic signed [SampleBits-1:0] smp_q;
  logic [2*LenW-1:0] prod;
  logic signed [AccW-1:0] acc;

  logic div_start, div_done;
  logic [NumW-1:0] div_num, div_quot;
  logic [DenW-1:0] div_den;

  logic accept;
  logic [6:0] eff, n_eff;
  logic [LenW-1:0] l_eff;
  logic [AccW-1:0] acc_abs;

  logic signed [SampleBits-1:0] s;
  logic fresh, first_ok, second_ok, half0, close;
  logic [6:0] ci0, done_n;
  logic [LenW-1:0] cl0, pmax0, psum0, best, lsum;
  logic [LenW-1:0] mean_sum;
  logic mean_close, res_set, len_div_go;
  logic [NumW-1:0] ldiv_num;
  logic [DenW-1:0] ldiv_den;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign eff    = (group_cycles == 7'd0) ? 7'd1 :
                  (group_cycles > 7'(MaxCycles)) ? 7'(MaxCycles) : group_cycles;
  assign n_eff  = (cidx == 7'd0) ? 7'd1 : (cidx > 7'(MaxCycles)) ? 7'(MaxCycles) : cidx;
  assign l_eff  = (olen == '0) ? LenW'(1) : olen;
  assign acc_abs = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);

  // push path decode
  always_comb begin
    s        = s_axis_tdata;
    fresh    = (gcount == '0);
    ci0      = fresh ? 7'd0 : cidx;
    half0    = fresh ? 1'b0 : half;
    cl0      = fresh ? '0 : cur_len;
    pmax0    = fresh ? '0 : pmax;
    psum0    = fresh ? '0 : psum;
    first_ok  = neg_first ? (s <= 0) : (s >= 0);
    second_ok = neg_first ? (s >= 0) : (s <= 0);
    close    = half0 && !second_ok;
    done_n   = ci0 + 7'd1;
    best     = (pmax0 > cl0) ? pmax0 : cl0;
    lsum     = psum0 + cl0;
  end

  assign mean_close = (state == S_IDLE) && accept && !s_axis_tuser[0] && !pending &&
                      close && (done_n >= eff) && use_mean;
  assign res_set = ((state == S_IDLE) && accept && !(s_axis_tuser[0] && pending) &&
                    !mean_close) ||
                   (((state == S_AVG) || (state == S_LEN_DIV)) && div_done);

  assign ldiv_num = NumW'({mean_sum, 1'b0}) + NumW'(cidx);
  assign ldiv_den = DenW'({cidx, 1'b0});

  wga_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    if (state == S_PDIV0) begin
      div_start = 1'b1;
      div_num   = NumW'({prod, 1'b0}) + NumW'(l_eff);
      div_den   = DenW'({l_eff, 1'b0});
    end else if (state == S_AVG0) begin
      div_start = 1'b1;
      div_num   = NumW'({acc_abs, 1'b0}) + NumW'(n_eff);
      div_den   = DenW'({n_eff, 1'b0});
    end else if (len_div_go) begin
      div_start = 1'b1;
      div_num   = ldiv_num;
      div_den   = ldiv_den;
    end
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state == S_IDLE) && (!m_axis_tvalid || m_axis_tready);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && s_axis_tuser[0] && pending) state_next = S_PRD;
        else if (mean_close) state_next = S_LEN_DIV;
      end
      S_LEN_DIV: if (div_done) state_next = S_IDLE;
      S_PRD:     state_next = S_PMUL;
      S_PMUL:    state_next = S_PDIV0;
      S_PDIV0:   state_next = S_PDIV;
      S_PDIV:    if (div_done) state_next = S_PSMP;
      S_PSMP:    state_next = S_PACC;
      S_PACC:    state_next = (kcnt + 7'd1 >= n_eff) ? S_AVG0 : S_PRD;
      S_AVG0:    state_next = S_AVG;
      S_AVG:     if (div_done) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory reads
  always_ff @(posedge clk) begin
    rd_len   <= lmem[kcnt[CidxW-1:0]];
    rd_start <= tmem[kcnt[CidxW-1:0]];
    smp_q    <= smem[saddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      group_cycles  <= 7'd2;
      use_mean      <= 1'b0;
      neg_first     <= 1'b0;
      wp            <= '0;
      gcount        <= '0;
      cidx          <= '0;
      half          <= 1'b0;
      olen          <= '0;
      opos          <= '0;
      pending       <= 1'b0;
      m_axis_tvalid <= 1'b0;
      kcnt          <= '0;
    end else begin
      state <= state_next;
      m_axis_tvalid <= res_set || (m_axis_tvalid && !m_axis_tready);
      if (cfg_we) begin
        case (cfg_index)
          REG_GROUP_CYCLES: group_cycles <= cfg_data;
          REG_USE_MEAN:     use_mean     <= cfg_data[0];
          REG_NEG_FIRST:    neg_first    <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            m_axis_tdata <= '0;
            m_axis_tlast <= 1'b0;
            if (s_axis_tuser[0]) begin
              if (!pending) begin
                m_axis_tuser  <= ST_NONE;
              end else begin
                kcnt <= '0;
                acc  <= '0;
              end
            end else if (pending) begin
              m_axis_tuser  <= ST_REFUSED;
            end else begin
              m_axis_tuser <= ST_ACCEPTED;
              if (fresh) tmem[0] <= wp;
              if (close && done_n >= eff) begin
                cidx    <= done_n;
                smem[wp] <= s;
                wp      <= wp + 1'b1;
                gcount  <= LenW'(1);
                half    <= 1'b0;
                opos    <= '0;
                pending <= 1'b1;
                if (use_mean) begin
                  mean_sum <= lsum;
                end else begin
                  olen          <= best;
                end
              end else if (gcount >= LenW'(SampleDepth - 1)) begin
                cidx          <= '0;
                half          <= 1'b0;
                gcount        <= '0;
                m_axis_tuser  <= ST_OVERFLOW;
              end else if (close) begin
                cidx     <= done_n;
                tmem[done_n[CidxW-1:0]] <= wp;
                lmem[done_n[CidxW-1:0]] <= LenW'(1);
                cur_len  <= LenW'(1);
                pmax     <= best;
                psum     <= lsum;
                smem[wp] <= s;
                wp       <= wp + 1'b1;
                gcount   <= gcount + 1'b1;
                half     <= 1'b0;
              end else begin
                cidx     <= ci0;
                pmax     <= pmax0;
                psum     <= psum0;
                half     <= half0 | !first_ok;
                cur_len  <= cl0 + 1'b1;
                lmem[ci0[CidxW-1:0]] <= cl0 + 1'b1;
                smem[wp] <= s;
                wp       <= wp + 1'b1;
                gcount   <= gcount + 1'b1;
              end
            end
          end
        end
        S_LEN_DIV: begin
          if (div_done) olen <= div_quot[LenW-1:0];
        end
        S_PMUL: begin
          prod       <= rd_len * opos;
          start_hold <= rd_start;
        end
        S_PDIV: begin
          if (div_done) saddr <= start_hold + div_quot[AddrW-1:0];
        end
        S_PACC: begin
          acc  <= acc + AccW'(smp_q);
          kcnt <= kcnt + 7'd1;
        end
        S_AVG: begin
          if (div_done) begin
            m_axis_tuser  <= ST_GIVEN;
            m_axis_tdata  <= acc[AccW-1] ? 16'(-div_quot) : div_quot[15:0];
            if (opos + 1'b1 >= l_eff) begin
              m_axis_tlast <= 1'b1;
              pending      <= 1'b0;
              opos         <= '0;
              cidx         <= '0;
              half         <= 1'b0;
              tmem[0]      <= wp - 1'b1;
              lmem[0]      <= LenW'(1);
              cur_len      <= LenW'(1);
              pmax         <= '0;
              psum         <= '0;
            end else begin
              m_axis_tlast <= 1'b0;
              opos         <= opos + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // launch the mean length divide the cycle after the closing push
  always_ff @(posedge clk) begin
    if (rst) len_div_go <= 1'b0;
    else len_div_go <= mean_close;
  end

  a_pend_cycles: assert property (@(posedge clk) disable iff (rst)
    pending |-> cidx != 7'd0) else $error("pending group with no cycles");
  a_busy_noready: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !s_axis_tready) else $error("request taken while busy");
  a_last_given: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == ST_GIVEN)
    else $error("last flag without sample");

endmodule

### sim/waveset_group_averager_checker.sv
// Checker for the waveset group averager: watches the request, result and register
// write ports, predicts every result and compares it field by field. Depends on wga_pkg.
module waveset_group_averager_checker import wga_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic [2:0]  m_axis_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    status_t     status;
  } wave_result_t;

  logic signed [15:0] wave_store [SampleDepth];
  int unsigned        cyc_len [MaxCycles];
  int unsigned        cyc_start [MaxCycles];
  int unsigned        wr_ptr, grp_count, cyc_idx, second_half;
  int unsigned        out_len, out_pos, pending;
  int unsigned        n_cycles, mean_mode, neg_first;
  wave_result_t       expected_results[$];

  assign outstanding = expected_results.size();

  function automatic int unsigned active_cycles();
    if (n_cycles == 0) return 1;
    if (n_cycles > MaxCycles) return MaxCycles;
    return n_cycles;
  endfunction

  function automatic void store_wave(logic signed [15:0] s);
    wave_store[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % SampleDepth;
  endfunction

  function automatic int unsigned group_length(int unsigned n);
    int unsigned best, total;
    best = 0;
    total = 0;
    for (int k = 0; k < n && k < MaxCycles; k++) begin
      if (cyc_len[k] > best) best = cyc_len[k];
      total += cyc_len[k];
    end
    if (mean_mode == 0 || n == 0) return best;
    return (2 * total + n) / (2 * n);
  endfunction

  function automatic void clear_group();
    cyc_idx = 0;
    second_half = 0;
    grp_count = 0;
  endfunction

  function automatic status_t predict_push(logic signed [15:0] s);
    bit          first_ok, second_ok;
    int unsigned ci, done;
    if (pending != 0) return ST_REFUSED;
    if (grp_count == 0) begin
      cyc_idx = 0;
      second_half = 0;
      cyc_start[0] = wr_ptr;
      cyc_len[0] = 0;
    end
    first_ok = neg_first ? (s <= 0) : (s >= 0);
    second_ok = neg_first ? (s >= 0) : (s <= 0);
    ci = cyc_idx % MaxCycles;
    if (second_half != 0 && !second_ok) begin
      done = ci + 1;
      if (done >= active_cycles()) begin
        cyc_idx = done;
        store_wave(s);
        grp_count = 1;
        second_half = 0;
        out_len = group_length(done);
        out_pos = 0;
        pending = 1;
        return ST_ACCEPTED;
      end
      if (grp_count >= SampleDepth - 1) begin
        clear_group();
        return ST_OVERFLOW;
      end
      cyc_idx = done;
      cyc_start[done % MaxCycles] = wr_ptr;
      cyc_len[done % MaxCycles] = 1;
      store_wave(s);
      grp_count++;
      second_half = 0;
      return ST_ACCEPTED;
    end
    if (grp_count >= SampleDepth - 1) begin
      clear_group();
      return ST_OVERFLOW;
    end
    if (second_half == 0 && !first_ok) second_half = 1;
    cyc_len[ci]++;
    store_wave(s);
    grp_count++;
    return ST_ACCEPTED;
  endfunction

  function automatic wave_result_t predict_pull();
    wave_result_t r;
    int unsigned  n, len_ref, j;
    longint       total, q, offs;
    r = '{sample: '0, last: 1'b0, status: ST_NONE};
    if (pending == 0) return r;
    n = cyc_idx;
    if (n == 0) n = 1;
    if (n > MaxCycles) n = MaxCycles;
    len_ref = (out_len == 0) ? 1 : out_len;
    j = out_pos;
    total = 0;
    for (int k = 0; k < n; k++) begin
      offs = (2 * longint'(cyc_len[k]) * j + len_ref) / (2 * longint'(len_ref));
      total += wave_store[(cyc_start[k] + offs) % SampleDepth];
    end
    if (total >= 0) q = (2 * total + n) / (2 * n);
    else q = -((-2 * total + n) / (2 * n));
    r.sample = q[15:0];
    r.status = ST_GIVEN;
    if (j + 1 >= len_ref) begin
      r.last = 1'b1;
      pending = 0;
      out_pos = 0;
      cyc_idx = 0;
      second_half = 0;
      cyc_start[0] = (wr_ptr + SampleDepth - 1) % SampleDepth;
      cyc_len[0] = 1;
    end else begin
      out_pos = j + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    wave_result_t want, got;
    int           bad;
    bad = 0;
    if (rst) begin
      wr_ptr <= 0;
      grp_count <= 0;
      cyc_idx <= 0;
      second_half <= 0;
      out_len <= 0;
      out_pos <= 0;
      pending <= 0;
      n_cycles <= 2;
      mean_mode <= 0;
      neg_first <= 0;
      errors <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_GROUP_CYCLES: n_cycles = cfg_data;
          REG_USE_MEAN: mean_mode = cfg_data[0];
          REG_NEG_FIRST: neg_first = cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == 1'b0)
          expected_results.push_back('{sample: '0, last: 1'b0,
                                       status: predict_push(s_axis_tdata)});
        else
          expected_results.push_back(predict_pull());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{sample: m_axis_tdata, last: m_axis_tlast, status: status_t'(m_axis_tuser)};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          bad++;
        end else begin
          want = expected_results.pop_front();
          if (got.sample !== want.sample) begin
            $display("%0t: sample expected %h actual %h", $time, want.sample, got.sample);
            bad++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            bad++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     m_axis_tuser);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
  end

endmodule

### sim/waveset_group_averager_tb.sv
// Testbench top for the waveset group averager: clock, reset, register writes and
// push/pull requests, with random gaps unless steady. Depends on wga_pkg, the DUT and the checker module.
module waveset_group_averager_tb;
  import wga_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 10000000;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;
  int          errors, outstanding;
  int          cycle_count;
  bit          steady;
  bit          wave_positive;
  int          run_left;

  waveset_group_averager DUT (.*);
  waveset_group_averager_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  task automatic send(bit pull, logic [15:0] value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= pull;
    s_axis_tdata <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [6:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] wave_sample();
    int unsigned pick;
    if (run_left == 0) begin
      wave_positive = !wave_positive;
      run_left = $urandom_range(1, 4);
    end
    run_left--;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return wave_positive ? 16'h7fff : 16'h8000;
    if (wave_positive) return 16'($urandom_range(1, 32767));
    return 16'(-int'($urandom_range(1, 32768)));
  endfunction

  task automatic run_phase(int n, bit mean, bit neg, int count, int pull_pct, bit calm);
    int unsigned pick;
    settle();
    write_reg(REG_GROUP_CYCLES, 7'(n));
    write_reg(REG_USE_MEAN, 7'(mean));
    write_reg(REG_NEG_FIRST, 7'(neg));
    steady = calm;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < pull_pct) send(1'b1, 16'($urandom));
      else if (pick < pull_pct + 8) send(1'b0, 16'($urandom));
      else send(1'b0, wave_sample());
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cycle_count = 0;
    steady = 1'b0;
    wave_positive = 1'b0;
    run_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(1'b1, 16'h0000);
    send(1'b0, 16'h7fff);
    send(1'b0, 16'h8000);
    send(1'b0, 16'h0000);
    send(1'b0, 16'h0001);
    send(1'b0, 16'hffff);
    send(1'b0, 16'h0005);
    send(1'b0, 16'h0007);
    repeat (6) send(1'b1, 16'hffff);

    run_phase(1, 1'b1, 1'b1, 120, 25, 1'b0);
    run_phase(64, 1'b0, 1'b0, 360, 8, 1'b0);
    run_phase(0, 1'b0, 1'b1, 80, 25, 1'b1);
    run_phase(5, 1'b1, 1'b1, 120, 20, 1'b0);
    run_phase(2, 1'b1, 1'b0, 120, 30, 1'b0);

    settle();
    repeat (60) send(1'b1, 16'h0000);

    run_phase(100, 1'b0, 1'b1, 100, 25, 1'b0);
    run_phase(127, 1'b1, 1'b0, 60, 20, 1'b0);

    settle();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/wga_pkg.sv
sv/wga_divider.sv
sv/waveset_group_averager.sv
sim/waveset_group_averager_checker.sv
sim/waveset_group_averager_tb.sv
